// ===== design/lfsa_pkg.sv =====
// Shared types and constants for the linked free-list slot allocator.
// Holds request codes, request/result structs and the default-link helper.
// No dependencies.
package lfsa_pkg;

    localparam int SLOT_W         = 6;
    localparam int POOL_SLOTS_DEF = 32;
    localparam int CFG_RESET      = 32;
    localparam int MAX_RESULTS    = 32;

    localparam logic [SLOT_W-1:0] INVALID_LINK = 6'd63;

    // request type codes
    localparam logic [2:0] REQ_ALLOC_ONE   = 3'd0;
    localparam logic [2:0] REQ_ALLOC_CHAIN = 3'd1;
    localparam logic [2:0] REQ_FREE_ONE    = 3'd2;
    localparam logic [2:0] REQ_FREE_WALK   = 3'd3;
    localparam logic [2:0] REQ_FREE_HT     = 3'd4;
    localparam logic [2:0] REQ_REINIT      = 3'd5;

    // configuration register indexes
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [SLOT_W-1:0] count;
        logic [SLOT_W-1:0] link_in;
        logic [SLOT_W-1:0] slot_a;
        logic [SLOT_W-1:0] slot_b;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              ok;
        logic              last;
    } t_res;

    // Link held by an entry that has not been written since the last relink
    function automatic logic [SLOT_W-1:0] default_link(input logic [SLOT_W-1:0] idx,
                                                       input logic [SLOT_W-1:0] active);
        logic [SLOT_W:0] nxt;
        nxt = {1'b0, idx} + {{SLOT_W{1'b0}}, 1'b1};
        if (nxt < {1'b0, active}) begin
            return nxt[SLOT_W-1:0];
        end
        return INVALID_LINK;
    endfunction

endpackage

// ===== design/lfsa_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Used for the slot link table. No dependencies.
module lfsa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/linked_free_list_slot_allocator.sv =====
// Linked free-list slot allocator: one request at a time, results by strobe.
// Free one, free with tail, reinit and rejects answer straight from idle; alloc one reads
// the head's link, then pops it; alloc chain checks count slots in a first pass, then emits
// them in a second; an exhausted chain fails in the first pass; free by walking follows links.
// A new request is taken only in idle, once the last result is strobed; the receiver cannot stall.
// Reset and reinit clear all per-slot written flags together; there is no clearing pass.
// Depends on lfsa_pkg and lfsa_ram.
module linked_free_list_slot_allocator
    import lfsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel
    output logic        o_res_valid,
    output t_res        o_res,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] POOL_MAX = SLOT_W'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] ACTIVE_RESET =
        (CFG_RESET > POOL_SLOTS) ? SLOT_W'(POOL_SLOTS) : SLOT_W'(CFG_RESET);
    localparam logic [SLOT_W-1:0] MAX_CNT = SLOT_W'(MAX_RESULTS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_A_RD = 9'b000000010,
        S_A_WT = 9'b000000100,
        S_W_RD = 9'b000001000,
        S_W_WT = 9'b000010000,
        S_E_RD = 9'b000100000,
        S_E_WT = 9'b001000000,
        S_F_RD = 9'b010000000,
        S_F_WT = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [SLOT_W-1:0]   r_k, n_k;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_active, n_active;
    logic [POOL_SLOTS-1:0] r_written, n_written;
    logic                r_vld, n_vld;
    logic                r_out_valid, n_out_valid;
    t_res                r_res, n_res;
    logic [SLOT_W-1:0]   r_cfg;

    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wdata;
    logic [SLOT_W-1:0]   mem_rdata;
    logic [SLOT_W-1:0]   nxt;
    logic [SLOT_W-1:0]   cfg_clamped;
    logic                cfg_wr;

    // link table
    lfsa_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(POOL_SLOTS)
    ) u_links (
        .i_clk  (i_clk),
        .i_addr (mem_addr),
        .i_we   (mem_we),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);
    assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {26'd0, r_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= SLOT_W'(CFG_RESET);
        end else if (cfg_wr) begin
            r_cfg <= pwdata[SLOT_W-1:0];
        end
    end

    // managed slot count, saturated to 2..POOL_SLOTS
    always_comb begin
        if (r_cfg < SLOT_W'(2)) begin
            cfg_clamped = SLOT_W'(2);
        end else if (r_cfg > POOL_MAX) begin
            cfg_clamped = POOL_MAX;
        end else begin
            cfg_clamped = r_cfg;
        end
    end

    // link read back: unwritten entries hold their relinked default
    assign nxt = r_vld ? mem_rdata : default_link(r_cur, r_active);

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    // request sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cur       = r_cur;
        n_k         = r_k;
        n_head      = r_head;
        n_active    = r_active;
        n_written   = r_written;
        n_vld       = r_vld;
        n_out_valid = 1'b0;
        n_res       = r_res;
        mem_addr    = r_cur[AW-1:0];
        mem_we      = 1'b0;
        mem_wdata   = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req       = i_req;
                    n_out_valid = 1'b1;
                    n_res       = '{slot_out: INVALID_LINK, ok: 1'b0, last: 1'b1};
                    case (i_req.req_type)
                        REQ_ALLOC_ONE: begin
                            if (r_head < r_active) begin
                                n_out_valid = 1'b0;
                                n_cur       = r_head;
                                n_state     = S_A_RD;
                            end
                        end
                        REQ_ALLOC_CHAIN: begin
                            if (i_req.count != '0 && i_req.count <= MAX_CNT) begin
                                n_out_valid = 1'b0;
                                n_cur       = r_head;
                                n_k         = '0;
                                n_state     = S_W_RD;
                            end
                        end
                        REQ_FREE_ONE: begin
                            if (i_req.slot_a < r_active) begin
                                mem_addr  = i_req.slot_a[AW-1:0];
                                mem_we    = 1'b1;
                                n_written[i_req.slot_a[AW-1:0]] = 1'b1;
                                n_head    = i_req.slot_a;
                                n_res.ok  = 1'b1;
                            end
                        end
                        REQ_FREE_WALK: begin
                            if (i_req.slot_a < r_active) begin
                                n_out_valid = 1'b0;
                                n_cur       = i_req.slot_a;
                                n_k         = '0;
                                n_state     = S_F_RD;
                            end
                        end
                        REQ_FREE_HT: begin
                            if (i_req.slot_a < r_active && i_req.slot_b < r_active) begin
                                mem_addr  = i_req.slot_b[AW-1:0];
                                mem_we    = 1'b1;
                                n_written[i_req.slot_b[AW-1:0]] = 1'b1;
                                n_head    = i_req.slot_a;
                                n_res.ok  = 1'b1;
                            end
                        end
                        REQ_REINIT: begin
                            n_written = '0;
                            n_active  = cfg_clamped;
                            n_head    = '0;
                            n_res.ok  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // alloc one: fetch head's link, then pop it
            S_A_RD: begin
                n_vld   = r_written[r_cur[AW-1:0]];
                n_state = S_A_WT;
            end
            S_A_WT: begin
                mem_we      = 1'b1;
                mem_wdata   = r_req.link_in;
                n_written[r_cur[AW-1:0]] = 1'b1;
                n_head      = nxt;
                n_out_valid = 1'b1;
                n_res       = '{slot_out: r_cur, ok: 1'b1, last: 1'b1};
                n_state     = S_IDLE;
            end

            // alloc chain, first pass: check that count slots are free
            S_W_RD: begin
                if (r_cur >= r_active) begin
                    n_out_valid = 1'b1;
                    n_res       = '{slot_out: INVALID_LINK, ok: 1'b0, last: 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    n_vld   = r_written[r_cur[AW-1:0]];
                    n_state = S_W_WT;
                end
            end
            S_W_WT: begin
                if (r_k + SLOT_W'(1) == r_req.count) begin
                    n_cur   = r_head;
                    n_k     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_cur   = nxt;
                    n_k     = r_k + SLOT_W'(1);
                    n_state = S_W_RD;
                end
            end

            // alloc chain, second pass: emit slots, cut chain, move head
            S_E_RD: begin
                n_vld       = r_written[r_cur[AW-1:0]];
                n_out_valid = 1'b1;
                n_res       = '{slot_out: r_cur, ok: 1'b1,
                                last: (r_k + SLOT_W'(1) == r_req.count)};
                n_state     = S_E_WT;
            end
            S_E_WT: begin
                if (r_k + SLOT_W'(1) == r_req.count) begin
                    mem_we    = 1'b1;
                    mem_wdata = INVALID_LINK;
                    n_written[r_cur[AW-1:0]] = 1'b1;
                    n_head    = nxt;
                    n_state   = S_IDLE;
                end else begin
                    n_cur   = nxt;
                    n_k     = r_k + SLOT_W'(1);
                    n_state = S_E_RD;
                end
            end

            // free by walking: follow links to the tail, splice onto the list
            S_F_RD: begin
                n_vld   = r_written[r_cur[AW-1:0]];
                n_state = S_F_WT;
            end
            S_F_WT: begin
                if (nxt >= r_active) begin
                    mem_we      = 1'b1;
                    n_written[r_cur[AW-1:0]] = 1'b1;
                    n_head      = r_req.slot_a;
                    n_out_valid = 1'b1;
                    n_res       = '{slot_out: INVALID_LINK, ok: 1'b1, last: 1'b1};
                    n_state     = S_IDLE;
                end else if (r_k + SLOT_W'(1) == r_active) begin
                    // no tail within the managed slots: a loop
                    n_out_valid = 1'b1;
                    n_res       = '{slot_out: INVALID_LINK, ok: 1'b0, last: 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    n_cur   = nxt;
                    n_k     = r_k + SLOT_W'(1);
                    n_state = S_F_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_active    <= ACTIVE_RESET;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_active    <= n_active;
            r_written   <= n_written;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_cur <= n_cur;
        r_k   <= n_k;
        r_vld <= n_vld;
        r_res <= n_res;
    end

endmodule

// ===== dv/lfsa_grant_checker.sv =====
`timescale 1ns / 100ps
// Checker for the linked free-list slot allocator: mirrors the slot pool and
// compares every result strobe with the predicted reply. Depends on lfsa_pkg.
module lfsa_grant_checker
    import lfsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_res_valid,
    input  t_res        i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};

    // shadow of the pool
    logic [SLOT_W-1:0] pool_link [POOL_SLOTS_DEF];
    logic [SLOT_W-1:0] pool_head;
    int                pool_active;
    logic [SLOT_W-1:0] slots_reg;

    t_res pending_replies[$];
    t_res seen_reply;
    int   fails = 0;

    function automatic int clamp_slots(input logic [SLOT_W-1:0] v);
        if (v < 2) begin
            return 2;
        end
        if (v > POOL_SLOTS_DEF) begin
            return POOL_SLOTS_DEF;
        end
        return int'(v);
    endfunction

    // link the managed slots into one free list
    task automatic relink_pool();
        pool_active = clamp_slots(slots_reg);
        for (int i = 0; i < POOL_SLOTS_DEF; i++) begin
            pool_link[i] = (i + 1 < pool_active) ? SLOT_W'(i + 1) : INVALID_LINK;
        end
        pool_head = '0;
    endtask

    task automatic reply(input logic [SLOT_W-1:0] slot, input logic ok, input logic last);
        t_res r;
        r.slot_out = slot;
        r.ok       = ok;
        r.last     = last;
        pending_replies.push_back(r);
    endtask

    // apply one request to the shadow pool and queue the replies it causes
    task automatic run_pool_request(input t_req rq);
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] taken [MAX_RESULTS];
        logic              found;
        int                k;
        case (rq.req_type)
            REQ_ALLOC_ONE: begin
                if (pool_head >= pool_active) begin
                    reply(INVALID_LINK, 1'b0, 1'b1);
                end else begin
                    cur            = pool_head;
                    pool_head      = pool_link[cur];
                    pool_link[cur] = rq.link_in;
                    reply(cur, 1'b1, 1'b1);
                end
            end
            REQ_ALLOC_CHAIN: begin
                // zero or oversize counts fail like an empty pool
                found = (rq.count != 0) && (rq.count <= MAX_RESULTS);
                cur   = pool_head;
                for (k = 0; found && k < rq.count; k++) begin
                    if (cur >= pool_active) begin
                        found = 1'b0;
                    end else begin
                        taken[k] = cur;
                        cur      = pool_link[cur];
                    end
                end
                if (!found) begin
                    reply(INVALID_LINK, 1'b0, 1'b1);
                end else begin
                    pool_link[taken[rq.count - 1]] = INVALID_LINK;
                    pool_head = cur;
                    for (k = 0; k < rq.count; k++) begin
                        reply(taken[k], 1'b1, k + 1 == rq.count);
                    end
                end
            end
            REQ_FREE_ONE: begin
                if (rq.slot_a >= pool_active) begin
                    reply(INVALID_LINK, 1'b0, 1'b1);
                end else begin
                    pool_link[rq.slot_a] = pool_head;
                    pool_head            = rq.slot_a;
                    reply(INVALID_LINK, 1'b1, 1'b1);
                end
            end
            REQ_FREE_WALK: begin
                // a chain that loops back on itself is ignored
                found = 1'b0;
                cur   = rq.slot_a;
                if (rq.slot_a < pool_active) begin
                    for (k = 0; k < pool_active && !found; k++) begin
                        nxt = pool_link[cur];
                        if (nxt >= pool_active) begin
                            found = 1'b1;
                        end else begin
                            cur = nxt;
                        end
                    end
                end
                if (found) begin
                    pool_link[cur] = pool_head;
                    pool_head      = rq.slot_a;
                    reply(INVALID_LINK, 1'b1, 1'b1);
                end else begin
                    reply(INVALID_LINK, 1'b0, 1'b1);
                end
            end
            REQ_FREE_HT: begin
                if (rq.slot_a >= pool_active || rq.slot_b >= pool_active) begin
                    reply(INVALID_LINK, 1'b0, 1'b1);
                end else begin
                    pool_link[rq.slot_b] = pool_head;
                    pool_head            = rq.slot_a;
                    reply(INVALID_LINK, 1'b1, 1'b1);
                end
            end
            REQ_REINIT: begin
                relink_pool();
                reply(INVALID_LINK, 1'b1, 1'b1);
            end
            default: begin
                reply(INVALID_LINK, 1'b0, 1'b1);
            end
        endcase
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slots_reg = SLOT_W'(CFG_RESET);
            relink_pool();
            pending_replies.delete();
        end else begin
            if (i_res_valid) begin
                if (pending_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected result slot %0d ok %0b last %0b",
                                 $time, i_res.slot_out, i_res.ok, i_res.last);
                    end
                end else begin
                    seen_reply = pending_replies.pop_front();
                    if (i_res.slot_out !== seen_reply.slot_out || i_res.ok !== seen_reply.ok
                            || i_res.last !== seen_reply.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display(
                                "%0t: exp slot %0d ok %0b last %0b, got slot %0d ok %0b last %0b",
                                $time, seen_reply.slot_out, seen_reply.ok, seen_reply.last,
                                i_res.slot_out, i_res.ok, i_res.last);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == ADDR_SLOTS_IN_USE) begin
                slots_reg = i_pwdata[SLOT_W-1:0];
            end
            if (i_start && !i_busy) begin
                run_pool_request(i_req);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_replies.size();
    end

endmodule

// ===== dv/tb_linked_free_list_slot_allocator.sv =====
`timescale 1ns / 100ps
// Top of the slot allocator testbench: clock, reset, request and APB stimulus.
// Depends on lfsa_pkg, linked_free_list_slot_allocator and lfsa_grant_checker.
module tb_linked_free_list_slot_allocator
    import lfsa_pkg::*;
();

    // worst item: a 32-slot chain plus the longest gap, over ~500 items;
    // the limit is several times the run that this gives
    localparam int CYCLE_LIMIT = 600_000;
    localparam int REQ_W       = $bits(t_req);
    localparam int PHASE_ITEMS = 45;
    localparam int NUM_PHASES  = 9;
    localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_chain;

    typedef struct packed {
        logic              is_alloc;
        logic [SLOT_W-1:0] link_tail;
    } t_issued;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    t_req        i_req    = '0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        busy;
    logic        o_res_valid;
    t_res        o_res;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles   = 0;

    // chains currently held by the stimulus, and requests awaiting results
    t_chain            owned_chains[$];
    t_issued           issued_q[$];
    logic [SLOT_W-1:0] run_head = INVALID_LINK;
    logic [SLOT_W-1:0] run_tail = INVALID_LINK;
    logic [SLOT_W-1:0] cfg_slots = SLOT_W'(CFG_RESET);
    int                cur_active = CFG_RESET;
    logic [SLOT_W-1:0] cfg_values [NUM_PHASES] = '{2, 63, 17, 0, 32, 1, 33, 9, 5};

    linked_free_list_slot_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lfsa_grant_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // collect granted chains so later frees can return well-formed lists
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && issued_q.size() > 0) begin
            if (issued_q[0].is_alloc && o_res.ok && o_res.slot_out != INVALID_LINK) begin
                if (run_head == INVALID_LINK) begin
                    run_head = o_res.slot_out;
                end
                run_tail = o_res.slot_out;
            end
            if (o_res.last) begin
                if (issued_q[0].is_alloc && o_res.ok && run_head != INVALID_LINK) begin
                    owned_chains.push_back({run_head, (issued_q[0].link_tail != INVALID_LINK)
                                            ? issued_q[0].link_tail : run_tail});
                end
                run_head = INVALID_LINK;
                void'(issued_q.pop_front());
            end
        end
    end

    function automatic t_req mk_req(input logic [2:0] kind, input logic [SLOT_W-1:0] count,
                                    input logic [SLOT_W-1:0] link_in,
                                    input logic [SLOT_W-1:0] slot_a,
                                    input logic [SLOT_W-1:0] slot_b);
        t_req r;
        r.req_type = kind;
        r.count    = count;
        r.link_in  = link_in;
        r.slot_a   = slot_a;
        r.slot_b   = slot_b;
        return r;
    endfunction

    function automatic int clamp_slots(input logic [SLOT_W-1:0] v);
        if (v < 2) begin
            return 2;
        end
        if (v > POOL_SLOTS_DEF) begin
            return POOL_SLOTS_DEF;
        end
        return int'(v);
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end
        if (p < 88) begin
            return $urandom_range(1, 3);
        end
        if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // present one request and hold it until accepted
    task automatic issue(input t_req r, input logic [SLOT_W-1:0] link_tail, input int gap);
        t_issued it;
        it.is_alloc  = (r.req_type == REQ_ALLOC_ONE) || (r.req_type == REQ_ALLOC_CHAIN);
        it.link_tail = link_tail;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        issued_q.push_back(it);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input t_req r);
        issue(r, INVALID_LINK, rand_gap());
    endtask

    // drain all results, then allow the block to settle
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || issued_q.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [SLOT_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_SLOTS_IN_USE;
        pwdata  <= ($urandom & 32'hffff_ffc0) | 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_slots = val;
    endtask

    task automatic do_reinit(input int gap);
        wait_idle();
        owned_chains.delete();
        cur_active = clamp_slots(cfg_slots);
        issue(mk_req(REQ_REINIT, SLOT_W'($urandom), SLOT_W'($urandom),
                     SLOT_W'($urandom), SLOT_W'($urandom)), INVALID_LINK, gap);
    endtask

    // one random request, mostly alloc/free traffic over chains we hold
    task automatic rand_item(input logic calm);
        t_req              r;
        t_chain            c;
        logic [SLOT_W-1:0] link_tail;
        int                pick;
        int                idx;
        int                gap;
        r         = REQ_W'({$urandom, $urandom});
        link_tail = INVALID_LINK;
        gap       = calm ? 0 : rand_gap();
        pick      = $urandom_range(0, 99);
        if (pick < 4) begin
            do_reinit(gap);
            return;
        end
        if (pick >= 14) begin
            if (pick >= 55 && owned_chains.size() > 0) begin
                idx = $urandom_range(0, owned_chains.size() - 1);
                c   = owned_chains[idx];
                owned_chains.delete(idx);
                r.slot_a = c.head;
                r.slot_b = c.tail;
                case ($urandom_range(0, 2))
                    0:       r.req_type = (c.head == c.tail) ? REQ_FREE_ONE : REQ_FREE_HT;
                    1:       r.req_type = REQ_FREE_WALK;
                    default: r.req_type = REQ_FREE_HT;
                endcase
            end else if (pick < 35) begin
                r.req_type = REQ_ALLOC_ONE;
                r.link_in  = INVALID_LINK;
                // prepend to a held chain now and then
                if (owned_chains.size() > 0 && $urandom_range(0, 2) == 0) begin
                    idx = $urandom_range(0, owned_chains.size() - 1);
                    c   = owned_chains[idx];
                    owned_chains.delete(idx);
                    r.link_in = c.head;
                    link_tail = c.tail;
                end
            end else begin
                r.req_type = REQ_ALLOC_CHAIN;
                if ($urandom_range(0, 19) == 0) begin
                    r.count = SLOT_W'($urandom_range(1, MAX_RESULTS));
                end else begin
                    r.count = SLOT_W'($urandom_range(1, (cur_active < 6) ? cur_active : 6));
                end
            end
        end
        issue(r, link_tail, gap);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: boundaries, every request type, loops and exhaustion
        do_reinit(rand_gap());
        send(mk_req(REQ_ALLOC_ONE, 0, INVALID_LINK, 0, 0));
        send(mk_req(REQ_ALLOC_ONE, 0, 0, 0, 0));
        send(mk_req(REQ_ALLOC_CHAIN, 0, 0, 0, 0));
        send(mk_req(REQ_ALLOC_CHAIN, 33, 0, 0, 0));
        send(mk_req(REQ_ALLOC_CHAIN, 63, 63, 63, 63));
        send(mk_req(REQ_ALLOC_CHAIN, 4, 0, 0, 0));
        send(mk_req(REQ_FREE_WALK, 0, 0, 1, 0));
        send(mk_req(REQ_FREE_ONE, 0, 0, 32, 0));
        send(mk_req(REQ_FREE_ONE, 0, 0, 63, 0));
        send(mk_req(REQ_FREE_HT, 0, 0, 2, 5));
        send(mk_req(REQ_FREE_HT, 0, 0, 40, 3));
        send(mk_req(REQ_FREE_HT, 0, 0, 3, 63));
        send(mk_req(REQ_FREE_WALK, 0, 0, 63, 0));
        send(mk_req(3'd6, 63, 63, 63, 63));
        send(mk_req(3'd7, 0, 0, 0, 0));
        // slot 2 comes off the head linked to itself, then a walk from it loops
        send(mk_req(REQ_ALLOC_ONE, 0, 2, 0, 0));
        send(mk_req(REQ_FREE_WALK, 0, 0, 2, 0));
        do_reinit(rand_gap());
        send(mk_req(REQ_ALLOC_CHAIN, 32, 0, 0, 0));
        send(mk_req(REQ_ALLOC_ONE, 0, INVALID_LINK, 0, 0));
        send(mk_req(REQ_ALLOC_CHAIN, 1, 0, 0, 0));
        send(mk_req(REQ_FREE_ONE, 0, 0, 31, 0));
        send(mk_req(REQ_ALLOC_CHAIN, 2, 0, 0, 0));
        send(mk_req(REQ_ALLOC_ONE, 0, INVALID_LINK, 0, 0));
        do_reinit(rand_gap());

        // random traffic at the reset pool size
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            rand_item(1'b0);
        end

        // random traffic over a range of pool sizes, some phases without gaps
        cfg_values[NUM_PHASES-1] = SLOT_W'($urandom_range(0, 63));
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_slots(cfg_values[ph]);
            do_reinit(rand_gap());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rand_item(ph % 3 == 1);
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/lfsa_pkg.sv
design/lfsa_ram.sv
design/linked_free_list_slot_allocator.sv
dv/lfsa_grant_checker.sv
dv/tb_linked_free_list_slot_allocator.sv
